// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the codec RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge outside reset.
`define OPSEC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("opsec assertion failed");

// Antecedent in this cycle implies consequent in the same cycle.
`define OPSEC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("opsec implication failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define OPSEC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("opsec next-cycle check failed");

`endif

// ===== rtl/core/opsec_pkg.sv =====
// Types and constants of the order-preserving string escape codec.
`default_nettype none

package opsec_pkg;

   localparam int QueueDepth = 4;
   localparam int MaxResults = 4;
   localparam int SlotIdxW   = 2;

   localparam logic [7:0] NulByte = 8'h00;
   localparam logic [7:0] EscMark = 8'hFF;

   localparam logic [1:0] KindData = 2'd0;
   localparam logic [1:0] KindEnd  = 2'd1;
   localparam logic [1:0] KindErr  = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       has_byte;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
   } slot_type;

   // One accepted request expanded into its results, slot 0 first.
   typedef struct packed {
      slot_type [MaxResults-1:0] slots;
      logic [SlotIdxW-1:0]       last_idx;
   } desc_type;

endpackage

`default_nettype wire

// ===== rtl/core/opsec_front.sv =====
// Front end: accepts requests, holds mode and decode state, builds result lists.
`default_nettype none

module opsec_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire opsec_pkg::req_type req_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_data,
   output logic                    q_push,
   output opsec_pkg::desc_type     q_data,
   input  wire logic               q_full
);

   logic mode_ff, mode_in;
   logic nul_pending_ff, nul_pending_in;
   logic accept;
   logic pend_dec;
   logic closed;
   logic [2:0] n;
   opsec_pkg::desc_type desc;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   always_comb begin
      desc     = '0;
      n        = 3'd0;
      closed   = 1'b0;
      pend_dec = nul_pending_ff;
      if (!mode_ff) begin
         if (req_data.has_byte) begin
            desc.slots[n[1:0]].out_byte = req_data.in_byte;
            desc.slots[n[1:0]].kind     = opsec_pkg::KindData;
            n = n + 3'd1;
            if (req_data.in_byte == opsec_pkg::NulByte) begin
               desc.slots[n[1:0]].out_byte = opsec_pkg::EscMark;
               desc.slots[n[1:0]].kind     = opsec_pkg::KindData;
               n = n + 3'd1;
            end
         end
         if (req_data.end_mark) begin
            // terminator: two zero bytes, slots are already zero
            n = n + 3'd2;
         end
      end else begin
         if (req_data.has_byte) begin
            priority if (nul_pending_ff) begin
               pend_dec = 1'b0;
               priority if (req_data.in_byte == opsec_pkg::NulByte) begin
                  desc.slots[n[1:0]].kind = opsec_pkg::KindEnd;
                  closed = 1'b1;
               end else if (req_data.in_byte == opsec_pkg::EscMark) begin
                  desc.slots[n[1:0]].kind = opsec_pkg::KindData;
               end else begin
                  desc.slots[n[1:0]].kind = opsec_pkg::KindErr;
                  closed = 1'b1;
               end
               n = n + 3'd1;
            end else if (req_data.in_byte == opsec_pkg::NulByte) begin
               pend_dec = 1'b1;
            end else begin
               desc.slots[n[1:0]].out_byte = req_data.in_byte;
               desc.slots[n[1:0]].kind     = opsec_pkg::KindData;
               n = n + 3'd1;
            end
         end
         if (req_data.end_mark && !closed) begin
            // truncated input
            pend_dec = 1'b0;
            desc.slots[n[1:0]].kind = opsec_pkg::KindErr;
            n = n + 3'd1;
         end
      end
      desc.last_idx = n[1:0] - 2'd1;
   end

   assign q_push = accept && (n != 3'd0);
   assign q_data = desc;

   always_comb begin
      mode_in        = mode_ff;
      nul_pending_in = nul_pending_ff;
      if (csr_valid) begin
         mode_in        = csr_data;
         nul_pending_in = 1'b0;
      end else if (accept && mode_ff) begin
         nul_pending_in = pend_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 1'b0;
         nul_pending_ff <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         nul_pending_ff <= nul_pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/opsec_fifo.sv =====
// Short descriptor queue between front end and back end.
`default_nettype none

`include "assert_macros.svh"

module opsec_fifo #(
   parameter int DEPTH = opsec_pkg::QueueDepth
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire opsec_pkg::desc_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output opsec_pkg::desc_type      head,
   output logic                     empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   opsec_pkg::desc_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + CW'(1);
         2'b01:   cnt_in = cnt_ff - CW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `OPSEC_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CW'(DEPTH))
   `OPSEC_ASSERT(a_full_empty, clock, reset, !(full && empty))
   `OPSEC_ASSERT_IMPL(a_ptr_meet, clock, reset, empty || full, wr_ptr_ff == rd_ptr_ff)

endmodule

`default_nettype wire

// ===== rtl/core/opsec_back.sv =====
// Back end: walks descriptors to the output reg, one result per cycle when free.
`default_nettype none

`include "assert_macros.svh"

module opsec_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire opsec_pkg::desc_type q_head,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output opsec_pkg::rsp_type       rsp_data
);

   logic out_valid_ff, out_valid_in;
   opsec_pkg::rsp_type out_ff;
   logic [opsec_pkg::SlotIdxW-1:0] idx_ff, idx_in;
   logic load;
   logic is_last;
   opsec_pkg::slot_type cur;

   assign load    = !q_empty && (!out_valid_ff || rsp_pop);
   assign cur     = q_head.slots[idx_ff];
   assign is_last = (idx_ff == q_head.last_idx);
   assign q_pop   = load && is_last;

   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = is_last ? '0 : idx_ff + opsec_pkg::SlotIdxW'(1);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff.out_byte    <= cur.out_byte;
         out_ff.kind        <= cur.kind;
         out_ff.last_of_run <= is_last;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // mid-descriptor: the head must still be there
   `OPSEC_ASSERT_IMPL(a_idx_head, clock, reset, idx_ff != '0, !q_empty)
   `OPSEC_ASSERT_IMPL(a_idx_range, clock, reset, !q_empty, idx_ff <= q_head.last_idx)
   `OPSEC_ASSERT_NEXT(a_last_flag, clock, reset, q_pop, !rsp_empty && rsp_data.last_of_run)

endmodule

`default_nettype wire

// ===== rtl/core/order_preserving_string_escape_codec_unit.sv =====
// Top level of the order-preserving string escape codec.
//
// Streams sort-key string bytes in encode mode (csr_data 0: copy each byte, add 0xFF
// after 0x00, append 0x00 0x00 at end of value) or decode mode (csr_data 1: strip
// escapes, report end of value and errors). Requests enter through a queue-style port
// (req_push/req_full) and results leave through one (rsp_empty/rsp_pop). The front end
// expands each request into a list of up to four results in the cycle it is accepted;
// a QUEUE_DEPTH-entry descriptor queue feeds the back end, which emits one result per
// cycle from its output register while that register is empty or being popped.
// A request with no result takes no queue entry. With the back end idle, the first
// result of a request passes through the descriptor queue and then the output
// register before it is visible on rsp_data. req_full rises only when the descriptor
// queue is full. Write mode only while idle; a mode write also clears the pending-zero
// flag.
`default_nettype none

module order_preserving_string_escape_codec_unit #(
   parameter int QUEUE_DEPTH = opsec_pkg::QueueDepth
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire opsec_pkg::req_type req_data,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output opsec_pkg::rsp_type      rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_data
);

   logic                q_push, q_full, q_pop, q_empty;
   opsec_pkg::desc_type q_wdata, q_head;

   opsec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_push    (q_push),
      .q_data    (q_wdata),
      .q_full    (q_full)
   );

   opsec_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   opsec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
